// File: rtl/block_sorter_ascending_assert.svh
// Assertion macros used by the block sorter RTL.
// Depends on nothing; included by the file that carries assertions.
`ifndef BLOCK_SORTER_ASCENDING_ASSERT_SVH
`define BLOCK_SORTER_ASCENDING_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BSA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle of its trigger.
`define BSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bsa_pkg.sv
// Shared types for the block sorter: input and output words and cell control.
// Depends on nothing.
`default_nettype none

package bsa_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_in;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } t_out_word;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/block_sorter_ascending.sv
// Block sorter: loads a block of signed words and returns them in ascending order.
// Depends on bsa_pkg, bsa_cell and block_sorter_ascending_assert.svh.
//
// Usage:
//   Input words arrive on i_in_valid / o_in_ready with i_in_word; last_in closes a block.
//   Each accepted word is inserted into its place in a row of CAPACITY sorting cells,
//   so loading runs at one word per cycle. Words beyond CAPACITY are dropped and the
//   whole block is then marked with overflow.
//   After the closing word is accepted the block drains from the head cell, one
//   result word per cycle on o_out_valid / i_out_ready with o_out_word while the
//   receiver takes them; the first result reaches the output register once the state
//   has switched to draining and that register is free. The final word carries last_out.
//   o_in_ready is low while draining and rises once the final result is in the output
//   register, so the next block can load while that word waits.
//   A stalled receiver holds the output register and pauses the drain.
//   Reset (i_rst_n low, synchronous) empties every cell, clears the overflow flag
//   and the output valid flag, and returns the block to loading.
`default_nettype none
`include "block_sorter_ascending_assert.svh"

module block_sorter_ascending #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire bsa_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output bsa_pkg::t_out_word      o_out_word
);

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_dropped;
    logic                n_dropped;
    logic                r_out_valid;
    logic                n_out_valid;
    bsa_pkg::t_out_word  r_out_word;
    bsa_pkg::t_out_word  n_out_word;

    bsa_pkg::t_cell_ctl  w_ctl;
    logic                w_accept;
    logic                w_full;

    logic signed [bsa_pkg::VALUE_W-1:0] w_cell_value [CAPACITY];
    logic [CAPACITY-1:0]                w_cell_valid;
    logic [CAPACITY-1:0]                w_cell_move;

    assign o_in_ready = (r_state == ST_LOAD);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = w_cell_valid[CAPACITY-1];

    assign w_ctl.insert = w_accept && !w_full;
    assign w_ctl.pop    = (r_state == ST_DRAIN) && (!r_out_valid || i_out_ready);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [bsa_pkg::VALUE_W-1:0] w_prev_value;
            logic                               w_prev_valid;
            logic                               w_prev_move;
            logic signed [bsa_pkg::VALUE_W-1:0] w_next_value;
            logic                               w_next_valid;

            if (gi == 0) begin : g_head
                assign w_prev_value = i_in_word.value;
                assign w_prev_valid = 1'b1;
                assign w_prev_move  = 1'b0;
            end else begin : g_body
                assign w_prev_value = w_cell_value[gi-1];
                assign w_prev_valid = w_cell_valid[gi-1];
                assign w_prev_move  = w_cell_move[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_next_value = '0;
                assign w_next_valid = 1'b0;
            end else begin : g_inner
                assign w_next_value = w_cell_value[gi+1];
                assign w_next_valid = w_cell_valid[gi+1];
            end

            bsa_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new_value  (i_in_word.value),
                .i_prev_value (w_prev_value),
                .i_prev_valid (w_prev_valid),
                .i_prev_move  (w_prev_move),
                .i_next_value (w_next_value),
                .i_next_valid (w_next_valid),
                .o_value      (w_cell_value[gi]),
                .o_valid      (w_cell_valid[gi]),
                .o_move       (w_cell_move[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        case (r_state)
            ST_LOAD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                end
                if (w_accept) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end
                    if (i_in_word.last_in) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_ctl.pop) begin
                    // The head cell leaves; the block ends when nothing follows it.
                    n_out_valid             = 1'b1;
                    n_out_word.sorted_value = w_cell_value[0];
                    n_out_word.last_out     = !w_cell_valid[1];
                    n_out_word.overflow     = r_dropped;
                    if (!w_cell_valid[1]) begin
                        n_state   = ST_LOAD;
                        n_dropped = 1'b0;
                    end
                end else if (i_out_ready) begin
                    n_out_valid = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
            r_out_word  <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `BSA_ASSERT_ALWAYS(a_cells_packed, i_clk, i_rst_n, ((w_cell_valid + CAPACITY'(1)) & w_cell_valid) == '0, "occupied cells are not contiguous from the head")
    `BSA_ASSERT_SAME(a_drain_nonempty, i_clk, i_rst_n, r_state == ST_DRAIN, w_cell_valid[0], "draining with an empty chain")
    `BSA_ASSERT_NEXT(a_close_starts_drain, i_clk, i_rst_n, w_accept && i_in_word.last_in, (r_state == ST_DRAIN) && w_cell_valid[0], "closing word did not start the drain")
    `BSA_ASSERT_SAME(a_load_holds_last, i_clk, i_rst_n, (r_state == ST_LOAD) && r_out_valid, r_out_word.last_out, "a word other than the last waits while loading")

endmodule

`default_nettype wire

// File: rtl/bsa_cell.sv
// One compare-and-shift cell of the sorting chain.
// Depends on bsa_pkg for the value width and the control struct.
`default_nettype none

module bsa_cell (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bsa_pkg::t_cell_ctl                i_ctl,
    input  wire logic signed [bsa_pkg::VALUE_W-1:0] i_new_value,
    input  wire logic signed [bsa_pkg::VALUE_W-1:0] i_prev_value,
    input  wire logic                              i_prev_valid,
    input  wire logic                              i_prev_move,
    input  wire logic signed [bsa_pkg::VALUE_W-1:0] i_next_value,
    input  wire logic                              i_next_valid,
    output logic signed [bsa_pkg::VALUE_W-1:0]      o_value,
    output logic                                   o_valid,
    output logic                                   o_move
);

    logic signed [bsa_pkg::VALUE_W-1:0] r_value;
    logic signed [bsa_pkg::VALUE_W-1:0] n_value;
    logic                               r_valid;
    logic                               n_valid;
    logic                               w_move;

    // A held value equal to the new one stays ahead of it, which keeps the order stable.
    assign w_move = !r_valid || (r_value > i_new_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.pop) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_ctl.insert) begin
            n_valid = r_valid || i_prev_valid;
            if (w_move) begin
                n_value = i_prev_move ? i_prev_value : i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_move  = w_move;

endmodule

`default_nettype wire
